// ===== design/sgpr_pkg.sv =====
package sgpr_pkg;

  // Glyph geometry and character range of the font ROM.
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int MAX_SCALE     = 7;
  localparam int EXP_W         = GLYPH_ROWS * MAX_SCALE;
  localparam int GLYPH_W       = GLYPH_COLS * 8;
  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd90;
  localparam logic [7:0] FALLBACK_CODE = 8'h3F;
  localparam logic [7:0] LOWER_FIRST   = 8'd97;
  localparam logic [7:0] LOWER_LAST    = 8'd122;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;

  // Page numbers cover every row a glyph can reach from the input range.
  localparam int PAGE_W = 5;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input transaction layout.
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int X_LSB       = 0;
  localparam int Y_LSB       = 9;
  localparam int CODE_LSB    = 17;
  localparam int SCALE_LSB   = 25;
  localparam int ADDR_LSB    = 28;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // What the back end has to do for one command.
  typedef enum logic [1:0] {
    K_NOP   = 2'd0,
    K_CLEAR = 2'd1,
    K_DRAW  = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [8:0]          x;
    logic [7:0]          y;
    logic [GLYPH_W-1:0]  glyph;
    logic [2:0]          scale;
    logic [PAGE_W-1:0]   p_first;
    logic [PAGE_W-1:0]   p_last;
    logic [9:0]          rd_addr;
  } cmd_t;

  // Font ROM for codes 32..90: column c sits in bits [c*8 +: 8], bit 0 at the top.
  function automatic logic [GLYPH_W-1:0] glyph_rom(input logic [5:0] idx);
    logic [GLYPH_W-1:0] g;
    case (idx)
      6'd0:  g = 40'h0000000000;
      6'd1:  g = 40'h00005F0000;
      6'd2:  g = 40'h0007000700;
      6'd3:  g = 40'h147F147F14;
      6'd4:  g = 40'h122A7F2A24;
      6'd5:  g = 40'h6264081323;
      6'd6:  g = 40'h5022554936;
      6'd7:  g = 40'h0000030500;
      6'd8:  g = 40'h0041221C00;
      6'd9:  g = 40'h001C224100;
      6'd10: g = 40'h082A1C2A08;
      6'd11: g = 40'h08083E0808;
      6'd12: g = 40'h0000305000;
      6'd13: g = 40'h0808080808;
      6'd14: g = 40'h0000606000;
      6'd15: g = 40'h0204081020;
      6'd16: g = 40'h3E4549513E;
      6'd17: g = 40'h00407F4200;
      6'd18: g = 40'h4649516142;
      6'd19: g = 40'h314B454121;
      6'd20: g = 40'h107F121418;
      6'd21: g = 40'h3945454527;
      6'd22: g = 40'h3049494A3C;
      6'd23: g = 40'h0305097101;
      6'd24: g = 40'h3649494936;
      6'd25: g = 40'h1E29494906;
      6'd26: g = 40'h0000363600;
      6'd27: g = 40'h0000365600;
      6'd28: g = 40'h4122140800;
      6'd29: g = 40'h1414141414;
      6'd30: g = 40'h0008142241;
      6'd31: g = 40'h0609510102;
      6'd32: g = 40'h3E41794932;
      6'd33: g = 40'h7E1111117E;
      6'd34: g = 40'h364949497F;
      6'd35: g = 40'h224141413E;
      6'd36: g = 40'h1C2241417F;
      6'd37: g = 40'h414949497F;
      6'd38: g = 40'h010109097F;
      6'd39: g = 40'h325141413E;
      6'd40: g = 40'h7F0808087F;
      6'd41: g = 40'h00417F4100;
      6'd42: g = 40'h013F414020;
      6'd43: g = 40'h412214087F;
      6'd44: g = 40'h404040407F;
      6'd45: g = 40'h7F0204027F;
      6'd46: g = 40'h7F1008047F;
      6'd47: g = 40'h3E4141413E;
      6'd48: g = 40'h060909097F;
      6'd49: g = 40'h5E2151413E;
      6'd50: g = 40'h462919097F;
      6'd51: g = 40'h3149494946;
      6'd52: g = 40'h01017F0101;
      6'd53: g = 40'h3F4040403F;
      6'd54: g = 40'h1F2040201F;
      6'd55: g = 40'h7F2018207F;
      6'd56: g = 40'h6314081463;
      6'd57: g = 40'h0304780403;
      6'd58: g = 40'h4345495161;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Stretches one 7-row font column vertically: bit k is font row k / scale.
  function automatic logic [EXP_W-1:0] expand_col(input logic [6:0] col,
                                                  input logic [2:0] scale);
    logic [63:0]      colx;
    logic [EXP_W-1:0] e;
    colx = 64'(col);
    e    = '0;
    for (int k = 0; k < EXP_W; k++) begin
      case (scale)
        3'd1: e[k] = colx[k];
        3'd2: e[k] = colx[k / 2];
        3'd3: e[k] = colx[k / 3];
        3'd4: e[k] = colx[k / 4];
        3'd5: e[k] = colx[k / 5];
        3'd6: e[k] = colx[k / 6];
        3'd7: e[k] = colx[k / 7];
        default: e[k] = 1'b0;
      endcase
    end
    return e;
  endfunction

endpackage

// ===== design/scaled_glyph_page_rasterizer.sv =====
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   in_tuser operation, in_tdata glyph and address
// out_     master     out_tvalid/out_tready out_tdata read_data, one per input transaction
//
// Every input transaction gives exactly one output transaction, in order, once its
// store work is done: a read reads one store byte, a clear writes every store byte,
// a draw does one store read-modify-write per page of each on-screen scaled column and
// steps past each off-screen column (5*scale columns in all).
// After reset the store is swept to zero, one byte a cycle, with in_tready held low.
// A two-entry command queue and the output register let either side stall.
module scaled_glyph_page_rasterizer #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // x_pos[8:0], y_pos[16:9], char_code[24:17], scale[27:25], read_address[37:28]
  input  logic [sgpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [sgpr_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_data[7:0]
  output logic [sgpr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sgpr_pkg::*;

  logic init_done;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  // Front end: accepts and classifies transactions.
  sgpr_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue.
  sgpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // Back end: store sequencer and output register.
  sgpr_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/sgpr_ram.sv =====
module sgpr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sgpr_front.sv =====
module sgpr_front #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgpr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [sgpr_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                            init_done,
  input  logic                            q_full,
  output logic                            push,
  output sgpr_pkg::cmd_t                  push_cmd
);
  import sgpr_pkg::*;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;

  op_t               op;
  logic [8:0]        x_pos;
  logic [7:0]        y_pos;
  logic [7:0]        char_code;
  logic [2:0]        scale;
  logic [9:0]        read_address;
  logic [7:0]        folded;
  logic [7:0]        code;
  logic [5:0]        glyph_idx;
  logic [5:0]        scale_x7;
  logic [9:0]        last_row;
  logic [5:0]        raw_last;
  logic [PAGE_W-1:0] p_first;
  logic [PAGE_W-1:0] p_last;
  logic              draw_empty;
  logic              read_hit;
  kind_t             kind;

  // Unpack the transaction.
  assign op           = op_t'(in_tuser);
  assign x_pos        = in_tdata[X_LSB +: 9];
  assign y_pos        = in_tdata[Y_LSB +: 8];
  assign char_code    = in_tdata[CODE_LSB +: 8];
  assign scale        = in_tdata[SCALE_LSB +: 3];
  assign read_address = in_tdata[ADDR_LSB +: 10];

  // Fold lower case, then map anything outside the font to the fallback glyph.
  assign folded    = (char_code >= LOWER_FIRST && char_code <= LOWER_LAST) ?
                     char_code - CASE_OFFSET : char_code;
  assign code      = (folded < FIRST_CODE || folded > LAST_CODE) ? FALLBACK_CODE : folded;
  assign glyph_idx = 6'(code - FIRST_CODE);

  // Vertical extent of the glyph in pages, clipped to the display.
  assign scale_x7   = {scale, 3'b000} - {3'b000, scale};
  assign last_row   = {{2{y_pos[7]}}, y_pos} + {4'b0000, scale_x7} - 10'd1;
  assign raw_last   = last_row[8:3];
  assign p_first    = y_pos[7] ? '0 : y_pos[7:3];
  assign p_last     = (raw_last > 6'(PAGE_COUNT - 1)) ? PAGE_W'(PAGE_COUNT - 1) :
                      raw_last[PAGE_W-1:0];
  assign draw_empty = (scale == 3'd0) || last_row[9] ||
                      (p_first > PAGE_W'(PAGE_COUNT - 1));
  assign read_hit   = (32'(read_address) < STORE_BYTES);

  // Classify the operation into the work the back end must do.
  always_comb begin
    case (op)
      OP_CLEAR: kind = K_CLEAR;
      OP_DRAW:  kind = draw_empty ? K_NOP : K_DRAW;
      OP_READ:  kind = read_hit ? K_READ : K_NOP;
      default:  kind = K_NOP;
    endcase
  end

  always_comb begin
    push_cmd.kind    = kind;
    push_cmd.x       = x_pos;
    push_cmd.y       = y_pos;
    push_cmd.glyph   = glyph_rom(glyph_idx);
    push_cmd.scale   = scale;
    push_cmd.p_first = p_first;
    push_cmd.p_last  = p_last;
    push_cmd.rd_addr = read_address;
  end

  // Accept while the queue has room and the store has been cleared after reset.
  assign in_tready = init_done && !q_full;
  assign push      = in_tvalid && in_tready;

endmodule

// ===== design/sgpr_queue.sv =====
module sgpr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sgpr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output sgpr_pkg::cmd_t head
);
  import sgpr_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t          entry_r [QUEUE_DEPTH];
  logic [QW-1:0] wptr_r, wptr_nxt;
  logic [QW-1:0] rptr_r, rptr_nxt;
  logic [QW:0]   count_r, count_nxt;

  assign full  = (count_r == (QW + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = push ? wptr_r + QW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + QW'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/sgpr_back.sv =====
module sgpr_back #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  sgpr_pkg::cmd_t                   head,
  output logic                             pop,
  output logic                             init_done,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sgpr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sgpr_pkg::*;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int LAST_ROWS   = DISPLAY_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_ROW_MASK = 8'((1 << LAST_ROWS) - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic signed [9:0] px_r, px_nxt;
  logic [2:0]        c_r, c_nxt;
  logic [2:0]        sx_r, sx_nxt;
  logic [PAGE_W-1:0] p_r, p_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              pipe_v_r, pipe_v_nxt;
  logic [AW-1:0]     pipe_addr_r, pipe_addr_nxt;
  logic [7:0]        pipe_mask_r, pipe_mask_nxt;
  logic [7:0]        res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  logic [6:0]        col_bits;
  logic [EXP_W-1:0]  col_exp;
  logic [EXP_W+7:0]  col_vec;
  logic signed [9:0] shift_full;
  logic [EXP_W+7:0]  col_shift;
  logic [7:0]        draw_mask;
  logic [AW-1:0]     draw_addr;
  logic              on_screen;
  logic              page_end;
  logic              col_end;
  logic              glyph_end;
  logic              draw_end;
  logic              clr_end;
  logic              out_free;

  sgpr_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pixel byte for the current scaled column and page: the stretched font
  // column is shifted so that store row page*8 lines up with bit 0.
  assign col_bits   = cmd_r.glyph[c_r*8 +: 7];
  assign col_exp    = expand_col(col_bits, cmd_r.scale);
  assign col_vec    = {col_exp, 8'h00};
  assign shift_full = $signed({2'b00, p_r, 3'b000}) -
                      $signed({{2{cmd_r.y[7]}}, cmd_r.y}) + 10'sd8;
  assign col_shift  = col_vec >> shift_full[5:0];
  assign draw_mask  = col_shift[7:0] & ((p_r == LAST_PAGE) ? LAST_ROW_MASK : 8'hFF);
  assign draw_addr  = AW'(int'(p_r) * DISPLAY_WIDTH + int'(px_r[8:0]));

  // Walk position flags.
  assign on_screen = !px_r[9] && (px_r < $signed(10'(DISPLAY_WIDTH)));
  assign page_end  = (p_r == cmd_r.p_last);
  assign col_end   = (sx_r == cmd_r.scale - 3'd1);
  assign glyph_end = col_end && (c_r == 3'(GLYPH_COLS - 1));
  assign draw_end  = glyph_end && (!on_screen || page_end);
  assign clr_end   = (clr_r == AW'(STORE_BYTES - 1));
  assign out_free  = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            K_CLEAR: state_nxt = ST_CLEAR;
            K_DRAW:  state_nxt = ST_DRAW;
            K_READ:  state_nxt = ST_READ;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DRAW: begin
        if (draw_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ:  state_nxt = ST_RDATA;
      ST_RDATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and store accesses per state.
  always_comb begin
    pop           = 1'b0;
    cmd_nxt       = cmd_r;
    px_nxt        = px_r;
    c_nxt         = c_r;
    sx_nxt        = sx_r;
    p_nxt         = p_r;
    clr_nxt       = clr_r;
    res_nxt       = res_r;
    pipe_v_nxt    = 1'b0;
    pipe_addr_nxt = draw_addr;
    pipe_mask_nxt = draw_mask;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_raddr     = draw_addr;
    // Write-back half of the read-modify-write issued in the previous cycle.
    ram_we        = pipe_v_r;
    ram_waddr     = pipe_addr_r;
    ram_wdata     = ram_rdata | pipe_mask_r;
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 8'h00;
        clr_nxt   = clr_end ? '0 : clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          px_nxt  = $signed({head.x[8], head.x});
          c_nxt   = '0;
          sx_nxt  = '0;
          p_nxt   = head.p_first;
          res_nxt = 8'h00;
        end
      end
      ST_DRAW: begin
        pipe_v_nxt = on_screen;
        if (on_screen && !page_end) begin
          p_nxt = p_r + PAGE_W'(1);
        end else begin
          // Move on to the next scaled column.
          p_nxt  = cmd_r.p_first;
          px_nxt = px_r + 10'sd1;
          if (col_end) begin
            sx_nxt = '0;
            c_nxt  = c_r + 3'd1;
          end else begin
            sx_nxt = sx_r + 3'd1;
          end
        end
      end
      ST_READ: begin
        ram_raddr = AW'(cmd_r.rd_addr);
      end
      ST_RDATA: begin
        res_nxt = ram_rdata;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    px_r        <= px_nxt;
    c_r         <= c_nxt;
    sx_r        <= sx_nxt;
    p_r         <= p_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    pipe_mask_r <= pipe_mask_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign init_done  = (state_r != ST_INIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import sgpr_pkg::*;

  // Display geometry at the default parameters of the block.
  localparam int DISP_W      = 128;
  localparam int DISP_H      = 64;
  localparam int PAGES       = (DISP_H + 7) / 8;
  localparam int STORE_BYTES = DISP_W * PAGES;
  localparam int FONT_FIRST  = 32;
  localparam int FONT_LAST   = 90;
  localparam int FONT_SUBST  = 63;
  localparam int RANDOM_ITEMS = 600;

  // Font columns for codes 32..90, five bytes per glyph in column order, bit 0 at the top.
  localparam bit [0:59*40-1] FONT_COLUMNS = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543
  };

  typedef struct {
    bit                drain;
    op_t               op;
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic [7:0]        code;
    logic [2:0]        scale;
    logic [9:0]        addr;
  } glyph_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted frame store and the bytes still owed by the block.
  logic [7:0] pixel_store [0:STORE_BYTES-1];
  logic [7:0] owed_bytes [$];
  glyph_cmd_t pending_cmds [$];
  glyph_cmd_t cur_cmd;

  logic in_fire = 1'b0;
  int   tx_gap = 0, tx_quiet = 0, rx_stall = 0, rx_quiet = 0;
  int   error_count = 0;
  int   n_draw = 0, n_read = 0, n_clear = 0, n_unused = 0, n_lit = 0, n_drain = 0;

  scaled_glyph_page_rasterizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_pause(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one command to the predicted store and returns the byte it should answer with.
  function automatic logic [7:0] apply_command(input glyph_cmd_t c);
    int         cx, cy, sc, code, px, py;
    logic [7:0] column;
    logic [7:0] answer;
    answer = '0;
    case (c.op)
      OP_CLEAR: begin
        for (int a = 0; a < STORE_BYTES; a++) pixel_store[a] = '0;
      end
      OP_DRAW: begin
        cx   = int'($signed(c.x));
        cy   = int'($signed(c.y));
        sc   = int'(c.scale);
        code = int'(c.code);
        // Fold lower case, then substitute a question mark for anything outside the font.
        if (code >= 97 && code <= 122) code = code - 32;
        if (code < FONT_FIRST || code > FONT_LAST) code = FONT_SUBST;
        for (int col = 0; col < 5; col++) begin
          column = FONT_COLUMNS[(code - FONT_FIRST) * 40 + col * 8 +: 8];
          for (int row = 0; row < 7; row++) begin
            if (column[row]) begin
              for (int sy = 0; sy < sc; sy++) begin
                for (int sx = 0; sx < sc; sx++) begin
                  px = cx + col * sc + sx;
                  py = cy + row * sc + sy;
                  if (px >= 0 && px < DISP_W && py >= 0 && py < DISP_H)
                    pixel_store[(py / 8) * DISP_W + px][py % 8] = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        if (int'(c.addr) < STORE_BYTES) answer = pixel_store[c.addr];
      end
      default: ;
    endcase
    return answer;
  endfunction

  function automatic glyph_cmd_t make_cmd(input op_t op, input int x, input int y,
                                          input int code, input int scale, input int addr);
    glyph_cmd_t c;
    c.drain = 1'b0;
    c.op    = op;
    c.x     = x[8:0];
    c.y     = y[7:0];
    c.code  = code[7:0];
    c.scale = scale[2:0];
    c.addr  = addr[9:0];
    return c;
  endfunction

  function automatic glyph_cmd_t make_drain();
    glyph_cmd_t c;
    c       = make_cmd(OP_NONE, 0, 0, 0, 0, 0);
    c.drain = 1'b1;
    return c;
  endfunction

  // Input side: presents queued commands, with random gaps and drain pauses.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
        in_tvalid <= 1'b0;
        if (owed_bytes.size() == 0) begin
          void'(pending_cmds.pop_front());
          n_drain++;
        end
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_tuser  <= cur_cmd.op;
        in_tdata  <= {2'b00, cur_cmd.addr, cur_cmd.scale, cur_cmd.code, cur_cmd.y, cur_cmd.x};
        in_tvalid <= 1'b1;
        if (tx_quiet > 0) tx_quiet--;
        else if ($urandom_range(0, 63) == 0) tx_quiet = $urandom_range(16, 64);
        tx_gap = pick_pause(tx_quiet > 0);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rx_quiet > 0) rx_quiet--;
      else if ($urandom_range(0, 63) == 0) rx_quiet = $urandom_range(16, 64);
      rx_stall = pick_pause(rx_quiet > 0);
    end
  end

  // Accepted input transactions update the prediction; output transactions are checked.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      owed_bytes.push_back(apply_command(cur_cmd));
      case (cur_cmd.op)
        OP_CLEAR: n_clear++;
        OP_DRAW:  n_draw++;
        OP_READ:  n_read++;
        default:  n_unused++;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output transaction, data %02h", out_tdata));
      end else begin
        if (out_tdata !== owed_bytes[0])
          report_mismatch($sformatf("read_data %02h, predicted %02h", out_tdata, owed_bytes[0]));
        else if (owed_bytes[0] != 8'h00)
          n_lit++;
        void'(owed_bytes.pop_front());
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r, x, y, code, scale, page, col, addr;
    int last_x, last_y;
    last_x = 0;
    last_y = 0;
    for (int a = 0; a < STORE_BYTES; a++) pixel_store[a] = '0;

    // Directed part: empty store, case folding, substitution, scale extremes, clipping.
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 1023));
    pending_cmds.push_back(make_cmd(OP_DRAW, 0, 0, 65, 1, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 2));
    pending_cmds.push_back(make_cmd(OP_DRAW, 10, 8, 97, 2, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, DISP_W + 12));
    pending_cmds.push_back(make_cmd(OP_DRAW, 30, 0, 255, 1, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, 40, 0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 32));
    pending_cmds.push_back(make_cmd(OP_DRAW, 50, 0, 35, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 50));
    pending_cmds.push_back(make_cmd(OP_DRAW, -3, -5, 35, 7, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, 255, 127, 87, 4, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, -128, -128, 77, 7, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, 125, 60, 77, 3, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 1023));
    pending_cmds.push_back(make_cmd(OP_NONE, -1, -1, 255, 7, 1023));
    pending_cmds.push_back(make_cmd(OP_DRAW, 60, 16, 122, 1, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, 70, 16, 123, 1, 0));
    pending_cmds.push_back(make_cmd(OP_DRAW, 80, 16, 90, 1, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 2 * DISP_W + 72));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 2 * DISP_W + 62));
    pending_cmds.push_back(make_drain());

    // Random part: draws, clears and unused ops, with reads that mostly land on the glyphs just drawn.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 383) - 128;
        else x = $urandom_range(0, 140) - 12;
        if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 255) - 128;
        else y = $urandom_range(0, 76) - 10;
        r = $urandom_range(0, 99);
        if (r < 40) code = $urandom_range(65, 90);
        else if (r < 55) code = $urandom_range(97, 122);
        else if (r < 80) code = $urandom_range(32, 90);
        else code = $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 5) scale = 0;
        else if (r < 60) scale = $urandom_range(1, 2);
        else if (r < 85) scale = $urandom_range(3, 4);
        else scale = $urandom_range(5, 7);
        pending_cmds.push_back(make_cmd(OP_DRAW, x, y, code, scale, $urandom_range(0, 1023)));
        last_x = x;
        last_y = y;
      end else if (r < 90) begin
        if ($urandom_range(0, 3) == 0) begin
          addr = $urandom_range(0, 1023);
        end else begin
          page = (last_y < 0 ? 0 : last_y / 8) + $urandom_range(0, 4);
          if (page >= PAGES) page = $urandom_range(0, PAGES - 1);
          col = last_x + $urandom_range(0, 35);
          if (col < 0 || col >= DISP_W) col = $urandom_range(0, DISP_W - 1);
          addr = page * DISP_W + col;
        end
        pending_cmds.push_back(make_cmd(OP_READ, $urandom_range(0, 511), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 7), addr));
      end else if (r < 94) begin
        pending_cmds.push_back(make_cmd(OP_CLEAR, $urandom_range(0, 511), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 7),
                                        $urandom_range(0, 1023)));
      end else begin
        pending_cmds.push_back(make_cmd(OP_NONE, $urandom_range(0, 511), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 7),
                                        $urandom_range(0, 1023)));
      end
      if (n % 150 == 149) pending_cmds.push_back(make_drain());
    end

    // Single reset at the start of the run.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || in_tvalid || owed_bytes.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d draws, %0d reads (%0d with lit pixels), %0d clears, %0d unused-op",
             n_draw, n_read, n_lit, n_clear, n_unused);
    $display("commands, with %0d drain pauses on the input side.", n_drain);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
